// ----- sv/pkihi_pkg.sv -----
// Shared constants, types and the hash mixing function of the pair index.
package pkihi_pkg;

    localparam int BUCKET_BITS_DEF = 8;
    localparam int CAPACITY_DEF    = 1024;
    localparam int WORD_W          = 32;
    localparam int ENTRY_ID_W      = 10;

    // Command codes carried by an input beat
    localparam logic CMD_STORE = 1'b0;
    localparam logic CMD_GET   = 1'b1;

    // Sequencer states, one-hot
    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_HEAD = 6'b000010,
        S_LINK = 6'b000100,
        S_CMP  = 6'b001000,
        S_MISS = 6'b010000,
        S_RES  = 6'b100000
    } t_state;

    // Supplemental mixing: h*127 + (h >> 9) + (h >> 17), modulo 2^32
    function automatic logic [WORD_W-1:0] mix_hash(input logic [WORD_W-1:0] h);
        logic [WORD_W-1:0] r;
        begin
            r = (h << 7) - h;
            r = r + (h >> 9) + (h >> 17);
            return r;
        end
    endfunction

endpackage

// ----- sv/pkihi_bucket_table.sv -----
// Bucket head memory with per-bucket valid flags cleared at reset.
module pkihi_bucket_table
    import pkihi_pkg::*;
#(
    parameter int BUCKET_BITS = BUCKET_BITS_DEF,
    parameter int ID_W        = 10
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_rd_en,
    input  logic [BUCKET_BITS-1:0] i_rd_addr,
    input  logic                   i_wr_en,
    input  logic [BUCKET_BITS-1:0] i_wr_addr,
    input  logic [ID_W-1:0]        i_wr_head,
    output logic [ID_W-1:0]        o_rd_head,
    output logic                   o_rd_valid
);

    localparam int NUM_BUCKETS = 1 << BUCKET_BITS;

    logic [ID_W-1:0]        r_head_mem [NUM_BUCKETS];
    logic [NUM_BUCKETS-1:0] r_valid;
    logic [ID_W-1:0]        r_rd_head;
    logic                   r_rd_valid;

    // Write the new head and read through a registered output
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_head_mem[i_wr_addr] <= i_wr_head;
        end
        if (i_rd_en) begin
            r_rd_head <= r_head_mem[i_rd_addr];
        end
    end

    // Valid flags: clear all buckets at reset, mark on write
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid    <= '0;
            r_rd_valid <= 1'b0;
        end else begin
            if (i_wr_en) begin
                r_valid[i_wr_addr] <= 1'b1;
            end
            if (i_rd_en) begin
                r_rd_valid <= r_valid[i_rd_addr];
            end
        end
    end

    assign o_rd_head  = r_rd_head;
    assign o_rd_valid = r_rd_valid;

endmodule

// ----- sv/pkihi_entry_store.sv -----
// Entry memory: key, restriction and chain link of every interned pair.
module pkihi_entry_store
    import pkihi_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF,
    parameter int ID_W     = 10
) (
    input  logic              i_clk,
    input  logic              i_rd_en,
    input  logic [ID_W-1:0]   i_rd_addr,
    input  logic              i_wr_en,
    input  logic [ID_W-1:0]   i_wr_addr,
    input  logic [WORD_W-1:0] i_wr_key,
    input  logic [WORD_W-1:0] i_wr_restriction,
    input  logic [ID_W-1:0]   i_wr_next,
    input  logic              i_wr_next_valid,
    output logic [WORD_W-1:0] o_rd_key,
    output logic [WORD_W-1:0] o_rd_restriction,
    output logic [ID_W-1:0]   o_rd_next,
    output logic              o_rd_next_valid
);

    localparam int ENT_W = 2 * WORD_W + ID_W + 1;

    logic [ENT_W-1:0] r_mem [CAPACITY];
    logic [ENT_W-1:0] r_rd_data;

    // Write a new entry and read through a registered output
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= {i_wr_next_valid, i_wr_next, i_wr_restriction, i_wr_key};
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_key         = r_rd_data[WORD_W-1:0];
    assign o_rd_restriction = r_rd_data[2*WORD_W-1:WORD_W];
    assign o_rd_next        = r_rd_data[2*WORD_W+ID_W-1:2*WORD_W];
    assign o_rd_next_valid  = r_rd_data[ENT_W-1];

endmodule

// ----- sv/pair_key_id_hash_index_unit.sv -----
// Top level of the pair interning index: sequencer, chain walk and output register.
//
// Input channel: i_valid / o_stall with i_command, i_key, i_restriction, i_hash_in.
// A store interns the pair, a get only looks it up. Output channel: i_stall /
// o_valid with o_found, o_entry_id and o_table_full, one beat per input beat.
// The mixed hash selects a bucket; its chain is walked newest first through
// the entry memory, one entry per cycle, as each read returns the next link.
// An item passes through the head read, the link read, one compare per chain
// entry read and, when no entry matches (store or get), the miss state, up to
// the result state, where its result is loaded into the output register; the
// chain walk through the single read port of the entry memory sets its pace. The
// next beat is accepted in that loading cycle, so one item is in work at a time.
// A finished result waits in the output register while the receiver stalls;
// the sequencer holds its result until the register is free, and a new beat is
// taken while the old one still waits. Reset clears all bucket valid flags and
// the entry count at once, so the block is ready in the first cycle after it.
module pair_key_id_hash_index_unit
    import pkihi_pkg::*;
#(
    parameter int BUCKET_BITS = BUCKET_BITS_DEF,
    parameter int CAPACITY    = CAPACITY_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_stall,
    input  logic                  i_command,
    input  logic [WORD_W-1:0]     i_key,
    input  logic [WORD_W-1:0]     i_restriction,
    input  logic [WORD_W-1:0]     i_hash_in,
    output logic                  o_valid,
    input  logic                  i_stall,
    output logic                  o_found,
    output logic [ENTRY_ID_W-1:0] o_entry_id,
    output logic                  o_table_full
);

    localparam int ID_W  = $clog2(CAPACITY);
    localparam int CNT_W = $clog2(CAPACITY + 1);

    t_state                 r_state;
    logic [CNT_W-1:0]       r_count;
    logic                   r_command;
    logic [WORD_W-1:0]      r_key;
    logic [WORD_W-1:0]      r_restr;
    logic [BUCKET_BITS-1:0] r_bkt;
    logic [ID_W-1:0]        r_cur;
    logic                   r_res_found;
    logic [ID_W-1:0]        r_res_id;
    logic                   r_res_full;
    logic                   r_o_valid;
    logic                   r_o_found;
    logic [ENTRY_ID_W-1:0]  r_o_id;
    logic                   r_o_full;

    logic                   slot_free;
    logic                   accept;
    logic                   load_out;
    logic                   hit;
    logic                   is_full;
    logic                   miss_add;
    logic [WORD_W-1:0]      mixed;
    logic [ID_W+ENTRY_ID_W-1:0] res_id_ext;

    logic                   bkt_rd_en;
    logic [ID_W-1:0]        bkt_head;
    logic                   bkt_valid;
    logic                   ent_rd_en;
    logic [ID_W-1:0]        ent_rd_addr;
    logic [WORD_W-1:0]      ent_key;
    logic [WORD_W-1:0]      ent_restr;
    logic [ID_W-1:0]        ent_next;
    logic                   ent_next_valid;

    // Handshake and decode
    assign slot_free = !r_o_valid || !i_stall;
    assign load_out  = (r_state == S_RES) && slot_free;
    assign o_stall   = !((r_state == S_IDLE) || load_out);
    assign accept    = i_valid && !o_stall;
    assign mixed     = mix_hash(i_hash_in);
    assign hit       = (ent_key == r_key) && (ent_restr == r_restr);
    assign is_full   = (r_count == CNT_W'(CAPACITY));
    assign miss_add  = (r_state == S_MISS) && (r_command == CMD_STORE) && !is_full;

    // Memory port control
    assign bkt_rd_en   = (r_state == S_HEAD);
    assign ent_rd_en   = ((r_state == S_LINK) && bkt_valid)
                      || ((r_state == S_CMP) && !hit && ent_next_valid);
    assign ent_rd_addr = (r_state == S_LINK) ? bkt_head : ent_next;

    pkihi_bucket_table #(
        .BUCKET_BITS (BUCKET_BITS),
        .ID_W        (ID_W)
    ) u_bucket_table (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_rd_en    (bkt_rd_en),
        .i_rd_addr  (r_bkt),
        .i_wr_en    (miss_add),
        .i_wr_addr  (r_bkt),
        .i_wr_head  (r_count[ID_W-1:0]),
        .o_rd_head  (bkt_head),
        .o_rd_valid (bkt_valid)
    );

    pkihi_entry_store #(
        .CAPACITY (CAPACITY),
        .ID_W     (ID_W)
    ) u_entry_store (
        .i_clk            (i_clk),
        .i_rd_en          (ent_rd_en),
        .i_rd_addr        (ent_rd_addr),
        .i_wr_en          (miss_add),
        .i_wr_addr        (r_count[ID_W-1:0]),
        .i_wr_key         (r_key),
        .i_wr_restriction (r_restr),
        .i_wr_next        (bkt_head),
        .i_wr_next_valid  (bkt_valid),
        .o_rd_key         (ent_key),
        .o_rd_restriction (ent_restr),
        .o_rd_next        (ent_next),
        .o_rd_next_valid  (ent_next_valid)
    );

    // Sequencer, entry count and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_count   <= '0;
            r_o_valid <= 1'b0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (accept) r_state <= S_HEAD;
                end
                S_HEAD: begin
                    r_state <= S_LINK;
                end
                S_LINK: begin
                    r_state <= bkt_valid ? S_CMP : S_MISS;
                end
                S_CMP: begin
                    if (hit) begin
                        r_state <= S_RES;
                    end else if (!ent_next_valid) begin
                        r_state <= S_MISS;
                    end
                end
                S_MISS: begin
                    r_state <= S_RES;
                end
                S_RES: begin
                    if (slot_free) r_state <= accept ? S_HEAD : S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
            if (miss_add) begin
                r_count <= r_count + CNT_W'(1);
            end
            if (load_out) begin
                r_o_valid <= 1'b1;
            end else if (!i_stall) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    // Capture the beat, track the chain position and build the result
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_command <= i_command;
            r_key     <= i_key;
            r_restr   <= i_restriction;
            r_bkt     <= mixed[BUCKET_BITS-1:0];
        end
        if (r_state == S_LINK) begin
            r_cur <= bkt_head;
        end else if ((r_state == S_CMP) && !hit) begin
            r_cur <= ent_next;
        end
        if ((r_state == S_CMP) && hit) begin
            r_res_found <= 1'b1;
            r_res_id    <= r_cur;
            r_res_full  <= 1'b0;
        end else if (r_state == S_MISS) begin
            r_res_found <= 1'b0;
            r_res_id    <= '0;
            r_res_full  <= (r_command == CMD_STORE) && is_full;
        end
    end

    // Output register: hold while the receiver stalls
    assign res_id_ext = {{ENTRY_ID_W{1'b0}}, r_res_id};

    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_o_found <= r_res_found;
            r_o_id    <= res_id_ext[ENTRY_ID_W-1:0];
            r_o_full  <= r_res_full;
        end
    end

    assign o_valid      = r_o_valid;
    assign o_found      = r_o_found;
    assign o_entry_id   = r_o_id;
    assign o_table_full = r_o_full;

    // A hit never names an entry that was not yet added
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_CMP) && hit) |-> ({1'b0, r_cur} < (ID_W + 1)'(r_count)))
        else $error("hit on an entry beyond the entry count");

    // The entry count stays within the capacity
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(CAPACITY))
        else $error("entry count beyond capacity");

    // The count moves only when a store miss adds an entry
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && (r_count != $past(r_count))) |-> $past(miss_add))
        else $error("entry count changed without an insert");

    // A result is never both a hit and a full-table report
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        load_out |-> !(r_res_found && r_res_full))
        else $error("result flags both found and table full");

endmodule
